// ----- rtl/core/fir_ar_pkg.sv -----
`default_nettype none

package fir_ar_pkg;

  // fixed geometry of the evaluator
  localparam int unsigned POINTS    = 256;
  localparam int unsigned COEF_BITS = 16;
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned KLEN_W    = 8;
  localparam int unsigned MAG_W     = 24;
  localparam int unsigned COS_W     = 15;
  localparam int unsigned PER_W     = $clog2(4 * POINTS);
  localparam int unsigned RI_W      = $clog2(POINTS + 1);
  localparam int unsigned PROD_W    = COEF_BITS + COS_W + 1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam int unsigned     MAG_MAX     = 24'hFF_FFFF;
  localparam int unsigned     RND_HALF    = 16384;

  // centre tap goes through the same multiplier: h * 2^14, doubled later
  localparam logic signed [COS_W:0] CTR_COS = 16'sd16384;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } fir_ar_state_e;

  typedef logic [POINTS:0][COS_W-1:0] cos_rom_t;

  // first-quadrant cosine in unsigned q0.15, series evaluated at elaboration
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t        rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned y;
    longint unsigned qv;
    for (int r = 0; r <= POINTS; r++) begin
      x  = (HALF_PI_Q30 * longint'(r) + longint'(POINTS / 2)) / POINTS;
      x2 = (x * x + (Q30_ONE >> 1)) >> 30;
      t  = Q30_ONE;
      y  = ((x2 * t) >> 30) / 132;
      t  = (y > Q30_ONE) ? 64'd0 : Q30_ONE - y;
      y  = ((x2 * t) >> 30) / 90;
      t  = (y > Q30_ONE) ? 64'd0 : Q30_ONE - y;
      y  = ((x2 * t) >> 30) / 56;
      t  = (y > Q30_ONE) ? 64'd0 : Q30_ONE - y;
      y  = ((x2 * t) >> 30) / 30;
      t  = (y > Q30_ONE) ? 64'd0 : Q30_ONE - y;
      y  = ((x2 * t) >> 30) / 12;
      t  = (y > Q30_ONE) ? 64'd0 : Q30_ONE - y;
      y  = ((x2 * t) >> 30) / 2;
      t  = (y > Q30_ONE) ? 64'd0 : Q30_ONE - y;
      qv = (t + 64'd16384) >> 15;
      if (qv > 64'd32767) begin
        qv = 64'd32767;
      end
      rom[r] = COS_W'(qv);
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

  // full-period cosine from the quarter-wave table
  function automatic logic signed [COS_W:0] cos_at(input logic [PER_W-1:0] k);
    logic [1:0]          quad;
    logic [RI_W-1:0]     r;
    logic [RI_W-1:0]     ri;
    logic signed [COS_W:0] v;
    quad = k[PER_W-1 -: 2];
    r    = RI_W'(k[PER_W-3:0]);
    ri   = quad[0] ? (RI_W'(POINTS) - r) : r;
    v    = $signed({1'b0, COS_ROM[ri]});
    return (quad[0] ^ quad[1]) ? -v : v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fir_ar_ram.sv -----
`default_nettype none

module fir_ar_ram #(
  parameter  int unsigned WIDTH = 16,
  parameter  int unsigned DEPTH = 128,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/fir_amplitude_response_core.sv -----
// an evaluate request steps through RUN, DRAIN and DONE, with the kernel length clamped to
//   MAX_TAPS, and loads its result once the result register is free; the next request is
//   taken in the cycle after the result is loaded
// throughput: one tap per cycle through the single tap ram port
// a load request gives no result
// reset: control, kernel length and output valid clear at once; tap ram holds no reset
`default_nettype none

module fir_amplitude_response_core #(
  parameter int unsigned MAX_TAPS = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration: kernel length
  input  logic                                 cfg_we_i,
  input  logic [fir_ar_pkg::KLEN_W-1:0]        cfg_wdata_i,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 cmd_i,
  input  logic [fir_ar_pkg::IDX_W-1:0]         index_i,
  input  logic signed [fir_ar_pkg::COEF_BITS-1:0] coef_value_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [fir_ar_pkg::IDX_W-1:0]         point_o,
  output logic [fir_ar_pkg::MAG_W-1:0]         magnitude_o
);

  import fir_ar_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_TAPS);
  localparam int unsigned LEN_W = $clog2(MAX_TAPS + 1);
  localparam int unsigned CMP_W = (LEN_W > KLEN_W) ? LEN_W : KLEN_W;
  localparam int unsigned IW    = (LEN_W > IDX_W) ? LEN_W : IDX_W;
  // room for every doubled product plus the centre tap
  localparam int unsigned ACC_W = PROD_W + 1 + LEN_W;
  localparam int unsigned SH_W  = ACC_W - 15;
  localparam int unsigned MW    = (SH_W > MAG_W) ? SH_W : MAG_W;

  fir_ar_state_e state_q, state_d;

  logic [KLEN_W-1:0]        kernel_length_q;

  // sequencer registers
  logic [AW-1:0]            term_left_q, term_left_d;
  logic [AW-1:0]            tap_addr_q, tap_addr_d;
  logic [AW-1:0]            ctr_addr_q, ctr_addr_d;
  logic                     ctr_pend_q, ctr_pend_d;
  logic [PER_W-1:0]         k_q, k_d;
  logic [PER_W-1:0]         step_q, step_d;
  logic [IDX_W-1:0]         point_q, point_d;

  // multiply-accumulate pipe
  logic                     s1_vld_q;
  logic signed [COS_W:0]    cos_s1_q;
  logic                     s2_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  // result register
  logic                     out_vld_q, out_vld_d;
  logic [IDX_W-1:0]         out_point_q;
  logic [MAG_W-1:0]         mag_q;

  // fsm outputs
  logic                     issue;
  logic                     issue_ctr;
  logic                     out_load;

  // request decode
  logic                     in_acc;
  logic                     eval_start;
  logic                     load_we;
  logic                     load_ok;

  // kernel length clamped to the store
  logic [CMP_W-1:0]         kl_ext;
  logic [LEN_W-1:0]         len_eff;
  logic [LEN_W-1:0]         half;

  // ram port
  logic [AW-1:0]            ram_addr;
  logic [COEF_BITS-1:0]     ram_rdata;
  logic signed [COEF_BITS-1:0] coef_s1;
  logic signed [COS_W:0]    cos_issue;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [ACC_W-1:0]  term_ext;

  // magnitude: abs and round half up in one add, then saturate
  logic                     acc_neg;
  logic [ACC_W-1:0]         mag_sel;
  logic [ACC_W-1:0]         mag_rnd;
  logic [MW-1:0]            mag_sh;
  logic [MAG_W-1:0]         mag_d;

  assign in_acc     = in_valid_i & in_ready_o;
  assign eval_start = in_acc & (cmd_i == CMD_EVAL);
  assign load_ok    = IW'(index_i) < IW'(MAX_TAPS);
  assign load_we    = in_acc & (cmd_i == CMD_LOAD) & load_ok;

  assign kl_ext  = CMP_W'(kernel_length_q);
  assign len_eff = (kl_ext > CMP_W'(MAX_TAPS)) ? LEN_W'(MAX_TAPS) : LEN_W'(kl_ext);
  assign half    = len_eff >> 1;

  // writes happen only when idle, reads only while running
  assign ram_addr = (state_q == ST_IDLE) ? AW'(index_i)
                  : (issue_ctr ? ctr_addr_q : tap_addr_q);

  fir_ar_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (MAX_TAPS)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .addr_i  (ram_addr),
    .wdata_i (coef_value_i),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (eval_start) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if ((term_left_q == '0) && !ctr_pend_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    issue_ctr  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_RUN: begin
        // upper-half taps first, centre tap last
        if (term_left_q != '0) begin
          issue = 1'b1;
        end else if (ctr_pend_q) begin
          issue     = 1'b1;
          issue_ctr = 1'b1;
        end
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        out_load = !out_vld_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  assign cos_issue = issue_ctr ? CTR_COS : cos_at(k_q);

  // sequencer next values
  always_comb begin
    term_left_d = term_left_q;
    tap_addr_d  = tap_addr_q;
    ctr_addr_d  = ctr_addr_q;
    ctr_pend_d  = ctr_pend_q;
    k_d         = k_q;
    step_d      = step_q;
    point_d     = point_q;
    if (eval_start) begin
      term_left_d = AW'(half);
      tap_addr_d  = AW'(len_eff - half);
      ctr_addr_d  = AW'(half);
      ctr_pend_d  = len_eff[0];
      // odd length starts at m = 2, even at m = 1; m steps by two
      k_d         = len_eff[0] ? PER_W'({index_i, 1'b0}) : PER_W'(index_i);
      step_d      = PER_W'({index_i, 1'b0});
      point_d     = index_i;
    end else if (issue) begin
      if (issue_ctr) begin
        ctr_pend_d = 1'b0;
      end else begin
        term_left_d = term_left_q - AW'(1);
        tap_addr_d  = tap_addr_q + AW'(1);
        k_d         = k_q + step_q;
      end
    end
  end

  assign coef_s1  = $signed(ram_rdata);
  assign prod_d   = coef_s1 * cos_s1_q;
  assign term_ext = {{(ACC_W - PROD_W - 1){prod_q[PROD_W-1]}}, prod_q, 1'b0};

  always_comb begin
    acc_d = acc_q;
    if (eval_start) begin
      acc_d = '0;
    end else if (s2_vld_q) begin
      acc_d = acc_q + term_ext;
    end
  end

  assign acc_neg = acc_q[ACC_W-1];
  assign mag_sel = acc_neg ? ~acc_q : acc_q;
  assign mag_rnd = mag_sel + (acc_neg ? ACC_W'(RND_HALF + 1) : ACC_W'(RND_HALF));
  assign mag_sh  = MW'(mag_rnd[ACC_W-1:15]);
  assign mag_d   = (mag_sh > MW'(MAG_MAX)) ? MAG_W'(MAG_MAX) : MAG_W'(mag_sh);

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      kernel_length_q <= '0;
      term_left_q     <= '0;
      ctr_pend_q      <= 1'b0;
      s1_vld_q        <= 1'b0;
      s2_vld_q        <= 1'b0;
      out_vld_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        kernel_length_q <= cfg_wdata_i;
      end
      term_left_q <= term_left_d;
      ctr_pend_q  <= ctr_pend_d;
      s1_vld_q    <= issue;
      s2_vld_q    <= s1_vld_q;
      out_vld_q   <= out_vld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    tap_addr_q <= tap_addr_d;
    ctr_addr_q <= ctr_addr_d;
    k_q        <= k_d;
    step_q     <= step_d;
    point_q    <= point_d;
    cos_s1_q   <= cos_issue;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    if (out_load) begin
      out_point_q <= point_q;
      mag_q       <= mag_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign point_o     = out_point_q;
  assign magnitude_o = mag_q;

endmodule

`default_nettype wire
